// ----- src/assert_macros.svh -----
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- src/su3e_pkg.sv -----
// Package: item types, codes and the product schedule.
`timescale 1ns / 1ps
package su3e_pkg;
  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 30;
  localparam int ACC_WIDTH   = 2 * VALUE_WIDTH + 2;
  localparam int NUM_STEPS   = 14;

  localparam logic [1:0] OP_LOAD_R = 2'd0;
  localparam logic [1:0] OP_LOAD_S = 2'd1;
  localparam logic [1:0] OP_PROD   = 2'd2;
  localparam logic [1:0] OP_CONJ   = 2'd3;

  // complex operand slots
  localparam logic [3:0] CR00 = 4'd0;
  localparam logic [3:0] CR01 = 4'd1;
  localparam logic [3:0] CR10 = 4'd2;
  localparam logic [3:0] CR11 = 4'd3;
  localparam logic [3:0] CS00 = 4'd4;
  localparam logic [3:0] CS01 = 4'd5;
  localparam logic [3:0] CS10 = 4'd6;
  localparam logic [3:0] CS11 = 4'd7;
  localparam logic [3:0] CT00 = 4'd8;
  localparam logic [3:0] CT01 = 4'd9;
  localparam logic [3:0] CT10 = 4'd10;
  localparam logic [3:0] CT11 = 4'd11;
  localparam logic [3:0] CP0  = 4'd12;
  localparam logic [3:0] CP1  = 4'd13;

  // destinations: 0..8 result element, else intermediate
  localparam logic [3:0] DEST_P0 = 4'd9;
  localparam logic [3:0] DEST_P1 = 4'd10;
  localparam logic [3:0] E_FROM_S10 = 4'd6;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [VALUE_WIDTH-1:0] a_re;
    logic signed [VALUE_WIDTH-1:0] a_im;
    logic signed [VALUE_WIDTH-1:0] b_re;
    logic signed [VALUE_WIDTH-1:0] b_im;
    logic signed [VALUE_WIDTH-1:0] c_re;
    logic signed [VALUE_WIDTH-1:0] c_im;
    logic signed [VALUE_WIDTH-1:0] d_re;
    logic signed [VALUE_WIDTH-1:0] d_im;
  } in_item_t;

  typedef struct packed {
    logic [3:0]              elem_index;
    logic signed [VALUE_WIDTH-1:0] elem_re;
    logic signed [VALUE_WIDTH-1:0] elem_im;
    logic                    last_elem;
  } out_item_t;

  typedef struct packed {
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] dest;
    logic       accum;
  } ucode_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic run;
    logic sub;
    logic msb;
  } mac_ctl_t;

  function automatic ucode_t ucode(input logic [3:0] step);
    ucode_t u;
    case (step)
      4'd0:    u = '{CR00, CS01, DEST_P0, 1'b0};
      4'd1:    u = '{CR10, CS01, DEST_P1, 1'b0};
      4'd2:    u = '{CR00, CS00, 4'd0, 1'b0};
      4'd3:    u = '{CR10, CS00, 4'd3, 1'b0};
      4'd4:    u = '{CS11, CT10, 4'd7, 1'b0};
      4'd5:    u = '{CS11, CT11, 4'd8, 1'b0};
      4'd6:    u = '{CP0,  CT10, 4'd1, 1'b0};
      4'd7:    u = '{CR01, CT00, 4'd1, 1'b1};
      4'd8:    u = '{CP0,  CT11, 4'd2, 1'b0};
      4'd9:    u = '{CR01, CT01, 4'd2, 1'b1};
      4'd10:   u = '{CP1,  CT10, 4'd4, 1'b0};
      4'd11:   u = '{CR11, CT00, 4'd4, 1'b1};
      4'd12:   u = '{CP1,  CT11, 4'd5, 1'b0};
      4'd13:   u = '{CR11, CT01, 4'd5, 1'b1};
      default: u = '{CR00, CS00, 4'd0, 1'b0};
    endcase
    return u;
  endfunction

  function automatic logic [3:0] transp(input logic [3:0] k);
    logic [3:0] t;
    case (k)
      4'd1:    t = 4'd3;
      4'd2:    t = 4'd6;
      4'd3:    t = 4'd1;
      4'd5:    t = 4'd7;
      4'd6:    t = 4'd2;
      4'd7:    t = 4'd5;
      default: t = k;
    endcase
    return t;
  endfunction
endpackage

// ----- src/su3e_mac.sv -----
// Bit-serial signed multiply-accumulate unit.
`timescale 1ns / 1ps
module su3e_mac import su3e_pkg::*; (
  input  logic                          clk,
  input  mac_ctl_t                      ctl,
  input  logic signed [VALUE_WIDTH-1:0] a,
  input  logic signed [VALUE_WIDTH-1:0] b,
  output logic signed [ACC_WIDTH-1:0]   acc
);
  logic [ACC_WIDTH-1:0]   mcand;
  logic [VALUE_WIDTH-1:0] mplier;
  logic [ACC_WIDTH-1:0]   addend;
  logic                   neg;

  always_comb begin
    neg    = ctl.sub ^ ctl.msb;
    addend = mplier[0] ? (mcand ^ {ACC_WIDTH{neg}}) : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.run) begin
      acc <= acc + $signed(addend) + $signed({{(ACC_WIDTH-1){1'b0}}, neg & mplier[0]});
    end
    if (ctl.load) begin
      mcand  <= {{(ACC_WIDTH-VALUE_WIDTH){a[VALUE_WIDTH-1]}}, a};
      mplier <= b;
    end else if (ctl.run) begin
      mcand  <= {mcand[ACC_WIDTH-2:0], 1'b0};
      mplier <= {1'b0, mplier[VALUE_WIDTH-1:1]};
    end
  end
endmodule

// ----- src/su2_embedded_su3_product.sv -----
// Top level: SU(3) product of three embedded SU(2) blocks, bit-serial.
//   channel | dir | handshake           | payload
//   in      | in  | in_valid / in_stall | in_data  (in_item_t)
//   out     | out | out_valid/out_stall | out_data (out_item_t)
// Loads of R or S are written straight into the operand registers. A T item runs 14 complex products,
// each 2 parts x 2 terms (an operand load, then a bit-serial multiply) plus a round step per part,
// all on one bit-serial MAC, then nine items out.
// Reset clears control only; R and S are undefined until loaded.
// in_stall is high from T acceptance until the ninth item is taken.
`timescale 1ns / 1ps
module su2_embedded_su3_product import su3e_pkg::*; #(
  parameter int FRAC = FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);
  `include "assert_macros.svh"

  localparam int BW = $clog2(VALUE_WIDTH);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam logic [ACC_WIDTH-1:0] HALF = ACC_WIDTH'(1) << (FRAC - 1);
  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic [2:0]    state;
  logic [3:0]    step;
  logic          part;
  logic          term;
  logic [BW-1:0] bitc;
  logic [3:0]    k;
  logic          conj;

  logic signed [VALUE_WIDTH-1:0] c_re [14];
  logic signed [VALUE_WIDTH-1:0] c_im [14];
  logic signed [VALUE_WIDTH-1:0] e_re [9];
  logic signed [VALUE_WIDTH-1:0] e_im [9];

  ucode_t   u;
  mac_ctl_t ctl;
  logic signed [VALUE_WIDTH-1:0] op_a, op_b, rv, prev, wv;
  logic signed [ACC_WIDTH-1:0]   acc, rsum, rq;
  logic signed [VALUE_WIDTH:0]   asum;
  logic          accept, msb;
  logic [3:0]    src;
  logic signed [VALUE_WIDTH-1:0] o_re, o_im;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign msb      = (bitc == BW'(VALUE_WIDTH - 1));

  always_comb begin
    u    = ucode(step);
    op_a = term ? c_im[u.x] : c_re[u.x];
    op_b = (part ^ term) ? c_im[u.y] : c_re[u.y];
    ctl.clear = (state == S_ROUND) || (accept && in_data.opcode[1]);
    ctl.load  = (state == S_LOAD);
    ctl.run   = (state == S_MUL);
    ctl.sub   = !part && term;
    ctl.msb   = msb;
    // round to nearest, shift, saturate
    rsum = acc + $signed(HALF);
    rq   = rsum >>> FRAC;
    if ((&rq[ACC_WIDTH-1:VALUE_WIDTH-1]) || !(|rq[ACC_WIDTH-1:VALUE_WIDTH-1]))
      rv = rq[VALUE_WIDTH-1:0];
    else
      rv = rq[ACC_WIDTH-1] ? VMIN : VMAX;
    prev = part ? e_im[u.dest] : e_re[u.dest];
    asum = {prev[VALUE_WIDTH-1], prev} + {rv[VALUE_WIDTH-1], rv};
    if (!u.accum)
      wv = rv;
    else if (asum[VALUE_WIDTH] != asum[VALUE_WIDTH-1])
      wv = asum[VALUE_WIDTH] ? VMIN : VMAX;
    else
      wv = asum[VALUE_WIDTH-1:0];
    src = conj ? transp(k) : k;
    o_re = (src == E_FROM_S10) ? c_re[CS10] : e_re[src];
    o_im = (src == E_FROM_S10) ? c_im[CS10] : e_im[src];
    if (conj) o_im = (o_im == VMIN) ? VMAX : -o_im;
  end

  su3e_mac u_mac (
    .clk (clk),
    .ctl (ctl),
    .a   (op_a),
    .b   (op_b),
    .acc (acc)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      c_re[{in_data.opcode[1], in_data.opcode[0] & !in_data.opcode[1], 2'd0}] <= in_data.a_re;
      c_im[{in_data.opcode[1], in_data.opcode[0] & !in_data.opcode[1], 2'd0}] <= in_data.a_im;
      c_re[{in_data.opcode[1], in_data.opcode[0] & !in_data.opcode[1], 2'd1}] <= in_data.b_re;
      c_im[{in_data.opcode[1], in_data.opcode[0] & !in_data.opcode[1], 2'd1}] <= in_data.b_im;
      c_re[{in_data.opcode[1], in_data.opcode[0] & !in_data.opcode[1], 2'd2}] <= in_data.c_re;
      c_im[{in_data.opcode[1], in_data.opcode[0] & !in_data.opcode[1], 2'd2}] <= in_data.c_im;
      c_re[{in_data.opcode[1], in_data.opcode[0] & !in_data.opcode[1], 2'd3}] <= in_data.d_re;
      c_im[{in_data.opcode[1], in_data.opcode[0] & !in_data.opcode[1], 2'd3}] <= in_data.d_im;
      conj <= (in_data.opcode == OP_CONJ);
    end
    if (state == S_ROUND) begin
      if (u.dest == DEST_P0 || u.dest == DEST_P1) begin
        if (part) c_im[(u.dest == DEST_P0) ? CP0 : CP1] <= rv;
        else      c_re[(u.dest == DEST_P0) ? CP0 : CP1] <= rv;
      end else if (part) begin
        e_im[u.dest] <= wv;
      end else begin
        e_re[u.dest] <= wv;
      end
    end
    if (state == S_OUT && (!out_valid || !out_stall) && k <= 4'd8) begin
      out_data.elem_index <= k;
      out_data.elem_re    <= o_re;
      out_data.elem_im    <= o_im;
      out_data.last_elem  <= (k == 4'd8);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
      part      <= 1'b0;
      term      <= 1'b0;
      bitc      <= '0;
      k         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && in_data.opcode[1]) begin
            step  <= '0;
            part  <= 1'b0;
            term  <= 1'b0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          bitc  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          bitc <= bitc + BW'(1);
          if (msb) begin
            if (!term) begin
              term  <= 1'b1;
              state <= S_LOAD;
            end else begin
              state <= S_ROUND;
            end
          end
        end
        S_ROUND: begin
          term  <= 1'b0;
          state <= S_LOAD;
          if (!part) begin
            part <= 1'b1;
          end else begin
            part <= 1'b0;
            if (step == 4'(NUM_STEPS - 1)) begin
              k     <= '0;
              state <= S_OUT;
            end else begin
              step <= step + 4'd1;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            if (k <= 4'd8) begin
              out_valid <= 1'b1;
              k         <= k + 4'd1;
            end else begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK_IMPL(a_out_in_out_state, out_valid, state == S_OUT, "result shown outside output phase")
  `CHK_IMPL(a_last_index, out_valid && out_data.last_elem, out_data.elem_index == 4'd8,
            "last flag on wrong element")
  `CHK_NEXT(a_t_starts, accept && in_data.opcode[1], state == S_LOAD,
            "product did not start after T")
endmodule
